[src/modular_exponentiation_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation unit
// Short forms of concurrent assertions, all clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define MEU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define MEU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define MEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Sequencer state type and the status bundle of the shared modular
// multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

   // Width of the transaction fields on the ports.
   localparam int unsigned FIELD_WIDTH = 32;

   // Reset value of the modulus register.
   localparam int unsigned MODULUS_RESET = 2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MULTIPLY,
      ST_SQUARE
   } state_type;

   // Status of the shared modular multiplier.
   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

[src/modexp_mulmod.sv]
// ----------------------------------------------------------------------------
// Shared modular multiplier
// Forms (multiplicand * multiplier) mod modulus exactly by MSB-first
// shift-and-add, one multiplier bit per cycle, with the accumulator kept
// below the modulus throughout.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [WIDTH-1:0]            multiplicand,
   input  logic [WIDTH-1:0]            multiplier,
   input  logic [WIDTH-1:0]            modulus,
   output logic [WIDTH-1:0]            product,
   output modexp_pkg::mm_status_type   status
);

   localparam int unsigned CNT_WIDTH = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]     acc_ff,   acc_in;
   logic [WIDTH-1:0]     mcand_ff, mcand_in;
   logic [WIDTH-1:0]     mplier_ff, mplier_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;

   logic [WIDTH+1:0] sum_wide;
   logic [WIDTH+1:0] mod_once;
   logic [WIDTH+1:0] mod_twice;
   logic [WIDTH+1:0] diff_once;
   logic [WIDTH+1:0] diff_twice;
   logic             last_step;

   // One step: acc = (2 * acc + bit * multiplicand) mod modulus. The sum
   // stays below three times the modulus, so at most two subtractions apply.
   always_comb begin
      sum_wide   = {1'b0, acc_ff, 1'b0}
                 + (mplier_ff[WIDTH-1] ? {2'b00, mcand_ff} : '0);
      mod_once   = {2'b00, modulus};
      mod_twice  = {1'b0, modulus, 1'b0};
      diff_once  = sum_wide - mod_once;
      diff_twice = sum_wide - mod_twice;
   end

   assign last_step = busy_ff && (count_ff == CNT_WIDTH'(1));

   // Next-value logic for the datapath and the step counter.
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = last_step;
      if (go) begin
         acc_in    = '0;
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         count_in  = CNT_WIDTH'(WIDTH);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (sum_wide >= mod_twice) begin
            acc_in = diff_twice[WIDTH-1:0];
         end else if (sum_wide >= mod_once) begin
            acc_in = diff_once[WIDTH-1:0];
         end else begin
            acc_in = sum_wide[WIDTH-1:0];
         end
         mplier_in = {mplier_ff[WIDTH-2:0], 1'b0};
         count_in  = count_ff - CNT_WIDTH'(1);
         busy_in   = !last_step;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[src/modular_exponentiation_unit.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base ** exponent mod modulus by right-to-left square-and-multiply
// on one shared, bit-serial modular multiplier.
//
// Usage: write the modulus through csr_write_enable / csr_write_data while
// the unit is idle; values below two are ignored. A transaction is taken on
// a clock edge with start high and busy low, carrying req_base_value and
// req_exponent. busy stays high until the result has been issued; the
// result appears on rsp_power_result for exactly one cycle with rsp_valid.
// The receiver cannot stall the unit and must take the result then.
// Each modular multiplication is a full pass of the shared multiplier. The
// base is reduced first (one such pass), then each exponent bit up to the
// highest set bit takes a check state, a squaring pass and, for a set bit,
// a multiplying pass ahead of the squaring. One transaction is in flight.
// Reset returns the sequencer to idle and sets the modulus to two.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit #(
   parameter int unsigned MOD_WIDTH = 32,
   parameter int unsigned EXP_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0]     req_base_value,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0]     req_exponent,
   output logic                                   rsp_valid,
   output logic [modexp_pkg::FIELD_WIDTH-1:0]     rsp_power_result,
   input  logic                                   csr_write_enable,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0]     csr_write_data
);

   modexp_pkg::state_type state_ff, state_in;

   logic [MOD_WIDTH-1:0] modulus_ff,  modulus_in;
   logic [MOD_WIDTH-1:0] base_ff,     base_in;
   logic [MOD_WIDTH-1:0] power_ff,    power_in;
   logic [EXP_WIDTH-1:0] exp_ff,      exp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [modexp_pkg::FIELD_WIDTH-1:0] rsp_result_ff, rsp_result_in;

   logic [MOD_WIDTH-1:0] csr_value;
   logic                 accept;

   logic                       mm_go;
   logic [MOD_WIDTH-1:0]       mm_multiplicand;
   logic [MOD_WIDTH-1:0]       mm_multiplier;
   logic [MOD_WIDTH-1:0]       mm_product;
   modexp_pkg::mm_status_type  mm_status;

   assign accept    = start && (state_ff == modexp_pkg::ST_IDLE);
   assign csr_value = MOD_WIDTH'(csr_write_data);

   // Modulus register: writes below two are dropped.
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_write_enable && (csr_value > MOD_WIDTH'(1))) begin
         modulus_in = csr_value;
      end
   end

   // Shared modular multiplier.
   modexp_mulmod #(
      .WIDTH (MOD_WIDTH)
   ) u_mulmod (
      .clock        (clock),
      .reset        (reset),
      .go           (mm_go),
      .multiplicand (mm_multiplicand),
      .multiplier   (mm_multiplier),
      .modulus      (modulus_ff),
      .product      (mm_product),
      .status       (mm_status)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = modexp_pkg::ST_REDUCE;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (mm_status.done) begin
               state_in = modexp_pkg::ST_CHECK;
            end
         end
         modexp_pkg::ST_CHECK: begin
            if (exp_ff == '0) begin
               state_in = modexp_pkg::ST_IDLE;
            end else if (exp_ff[0]) begin
               state_in = modexp_pkg::ST_MULTIPLY;
            end else begin
               state_in = modexp_pkg::ST_SQUARE;
            end
         end
         modexp_pkg::ST_MULTIPLY: begin
            if (mm_status.done) begin
               state_in = modexp_pkg::ST_SQUARE;
            end
         end
         modexp_pkg::ST_SQUARE: begin
            if (mm_status.done) begin
               state_in = modexp_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: multiplier commands and operand registers.
   always_comb begin
      mm_go           = 1'b0;
      mm_multiplicand = base_ff;
      mm_multiplier   = base_ff;
      base_in         = base_ff;
      power_in        = power_ff;
      exp_in          = exp_ff;
      rsp_valid_in    = 1'b0;
      rsp_result_in   = rsp_result_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            // Reduce the base as (1 * base) mod modulus.
            if (accept) begin
               mm_go           = 1'b1;
               mm_multiplicand = MOD_WIDTH'(1);
               mm_multiplier   = MOD_WIDTH'(req_base_value);
               exp_in          = EXP_WIDTH'(req_exponent);
               power_in        = MOD_WIDTH'(1);
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (mm_status.done) begin
               base_in = mm_product;
            end
         end
         modexp_pkg::ST_CHECK: begin
            if (exp_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = modexp_pkg::FIELD_WIDTH'(power_ff);
            end else if (exp_ff[0]) begin
               mm_go           = 1'b1;
               mm_multiplicand = power_ff;
               mm_multiplier   = base_ff;
            end else begin
               mm_go = 1'b1;
            end
         end
         modexp_pkg::ST_MULTIPLY: begin
            // Take the product and start the squaring straight away.
            if (mm_status.done) begin
               power_in = mm_product;
               mm_go    = 1'b1;
            end
         end
         modexp_pkg::ST_SQUARE: begin
            if (mm_status.done) begin
               base_in = mm_product;
               exp_in  = exp_ff >> 1;
            end
         end
         default: begin
            mm_go = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         modulus_ff   <= MOD_WIDTH'(modexp_pkg::MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operand and result registers.
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      power_ff      <= power_in;
      exp_ff        <= exp_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign busy             = (state_ff != modexp_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

   // Assertions.
   `MEU_ASSERT_ALWAYS(a_modulus_legal, clock, reset,
      modulus_ff > MOD_WIDTH'(1), "modulus below two")
   `MEU_ASSERT_SAME(a_mm_busy_in_transaction, clock, reset,
      mm_status.busy, busy, "multiplier runs while idle")
   `MEU_ASSERT_SAME(a_done_while_waiting, clock, reset, mm_status.done,
      (state_ff == modexp_pkg::ST_REDUCE) || (state_ff == modexp_pkg::ST_MULTIPLY)
         || (state_ff == modexp_pkg::ST_SQUARE),
      "multiplier result with no consumer")
   `MEU_ASSERT_NEXT(a_result_issued, clock, reset,
      (state_ff == modexp_pkg::ST_CHECK) && (exp_ff == '0),
      rsp_valid && !busy, "finished transaction not issued")
   `MEU_ASSERT_SAME(a_go_when_free, clock, reset,
      mm_go, !mm_status.busy, "multiplier started while busy")

endmodule
